>>> rtl/mxs_pkg.sv
// Shared types and codes for the max stack block.
package mxs_pkg;

    typedef enum logic [2:0] {
        CMD_PUSH    = 3'd0,
        CMD_POP     = 3'd1,
        CMD_TOP     = 3'd2,
        CMD_PEEK    = 3'd3,
        CMD_POP_MAX = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_PM_BASE,
        S_PM_SHIFT,
        S_RESP
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_PUSH,
        DP_POP,
        DP_TOP,
        DP_PEEK,
        DP_PM_START,
        DP_PM_BASE,
        DP_PM_STEP,
        DP_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        t_status code;
    } t_dp_ctl;

    typedef struct packed {
        logic empty;
        logic full;
        logic out_free;
        logic pm_short;
        logic pm_idx_zero;
        logic pm_last;
    } t_dp_stat;

endpackage

>>> rtl/mxs_ram.sv
// Generic simple dual-port RAM with registered read.
module mxs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/mxs_ctrl.sv
// Controller state machine for the max stack block.
module mxs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [2:0]       i_cmd,
    input  mxs_pkg::t_dp_stat i_stat,
    output logic             o_in_ready,
    output mxs_pkg::t_dp_ctl o_ctl
);

    mxs_pkg::t_state r_state;
    mxs_pkg::t_state n_state;
    mxs_pkg::t_cmd   r_cmd;
    mxs_pkg::t_cmd   n_cmd;
    logic            w_accept;
    logic            w_work;
    mxs_pkg::t_status w_code;

    assign o_in_ready = (r_state == mxs_pkg::S_IDLE) && i_stat.out_free;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        w_work = 1'b0;
        w_code = mxs_pkg::ST_OK;
        case (mxs_pkg::t_cmd'(i_cmd))
            mxs_pkg::CMD_PUSH: begin
                if (i_stat.full) begin
                    w_code = mxs_pkg::ST_FULL;
                end else begin
                    w_work = 1'b1;
                end
            end
            mxs_pkg::CMD_POP, mxs_pkg::CMD_TOP, mxs_pkg::CMD_PEEK,
            mxs_pkg::CMD_POP_MAX: begin
                if (i_stat.empty) begin
                    w_code = mxs_pkg::ST_EMPTY;
                end else begin
                    w_work = 1'b1;
                end
            end
            default: begin
                w_work = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mxs_pkg::S_IDLE;
            r_cmd   <= mxs_pkg::CMD_PUSH;
        end else begin
            r_state <= n_state;
            r_cmd   <= n_cmd;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        case (r_state)
            mxs_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_cmd   = mxs_pkg::t_cmd'(i_cmd);
                    n_state = w_work ? mxs_pkg::S_EXEC : mxs_pkg::S_RESP;
                end
            end
            mxs_pkg::S_EXEC: begin
                if (r_cmd == mxs_pkg::CMD_POP_MAX && !i_stat.pm_short) begin
                    n_state = i_stat.pm_idx_zero ? mxs_pkg::S_PM_SHIFT
                                                 : mxs_pkg::S_PM_BASE;
                end else begin
                    n_state = mxs_pkg::S_RESP;
                end
            end
            mxs_pkg::S_PM_BASE: begin
                n_state = mxs_pkg::S_PM_SHIFT;
            end
            mxs_pkg::S_PM_SHIFT: begin
                if (i_stat.pm_last) begin
                    n_state = mxs_pkg::S_RESP;
                end
            end
            mxs_pkg::S_RESP: begin
                if (i_stat.out_free) begin
                    n_state = mxs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mxs_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ctl.op   = mxs_pkg::DP_NOP;
        o_ctl.code = w_code;
        case (r_state)
            mxs_pkg::S_IDLE: begin
                if (w_accept) begin
                    o_ctl.op = mxs_pkg::DP_LOAD;
                end
            end
            mxs_pkg::S_EXEC: begin
                case (r_cmd)
                    mxs_pkg::CMD_PUSH:    o_ctl.op = mxs_pkg::DP_PUSH;
                    mxs_pkg::CMD_POP:     o_ctl.op = mxs_pkg::DP_POP;
                    mxs_pkg::CMD_TOP:     o_ctl.op = mxs_pkg::DP_TOP;
                    mxs_pkg::CMD_PEEK:    o_ctl.op = mxs_pkg::DP_PEEK;
                    mxs_pkg::CMD_POP_MAX: o_ctl.op = mxs_pkg::DP_PM_START;
                    default:              o_ctl.op = mxs_pkg::DP_NOP;
                endcase
            end
            mxs_pkg::S_PM_BASE: begin
                o_ctl.op = mxs_pkg::DP_PM_BASE;
            end
            mxs_pkg::S_PM_SHIFT: begin
                o_ctl.op = mxs_pkg::DP_PM_STEP;
            end
            mxs_pkg::S_RESP: begin
                if (i_stat.out_free) begin
                    o_ctl.op = mxs_pkg::DP_OUT;
                end
            end
            default: begin
                o_ctl.op = mxs_pkg::DP_NOP;
            end
        endcase
    end

endmodule

>>> rtl/mxs_dp.sv
// Datapath for the max stack block: entry memory, count, shift pass and result register.
module mxs_dp #(
    parameter int STACK_DEPTH = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mxs_pkg::t_dp_ctl  i_ctl,
    input  logic [31:0]       i_push_value,
    input  logic              i_out_ready,
    output mxs_pkg::t_dp_stat o_stat,
    output logic              o_out_valid,
    output logic [31:0]       o_read_value,
    output logic [1:0]        o_status
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int RW = 2 * VALUE_WIDTH + AW;

    logic [CW-1:0]                 r_count;
    logic signed [VALUE_WIDTH-1:0] r_push_value;
    logic [AW-1:0]                 r_ptr;
    logic signed [VALUE_WIDTH-1:0] r_run_max;
    logic [AW-1:0]                 r_run_pos;
    logic                          r_run_ok;
    logic [31:0]                   r_res_value;
    mxs_pkg::t_status              r_res_status;
    logic                          r_out_valid;
    logic [31:0]                   r_out_value;
    mxs_pkg::t_status              r_out_status;

    logic                          w_we;
    logic [AW-1:0]                 w_waddr;
    logic [RW-1:0]                 w_wdata;
    logic                          w_re;
    logic [AW-1:0]                 w_raddr;
    logic [RW-1:0]                 w_rdata;

    logic signed [VALUE_WIDTH-1:0] w_rd_val;
    logic signed [VALUE_WIDTH-1:0] w_rd_max;
    logic [AW-1:0]                 w_rd_pos;
    logic [AW-1:0]                 w_top;
    logic [AW-1:0]                 w_idx;
    logic                          w_short;
    logic                          w_last;
    logic signed [VALUE_WIDTH-1:0] w_push_max;
    logic [AW-1:0]                 w_push_pos;
    logic signed [VALUE_WIDTH-1:0] w_step_max;
    logic [AW-1:0]                 w_step_pos;

    mxs_ram #(
        .WIDTH(RW),
        .DEPTH(STACK_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_rd_val = w_rdata[VALUE_WIDTH-1:0];
    assign w_rd_max = w_rdata[2*VALUE_WIDTH-1:VALUE_WIDTH];
    assign w_rd_pos = w_rdata[RW-1:2*VALUE_WIDTH];
    assign w_top    = AW'(r_count - CW'(1));
    assign w_idx    = (w_rd_pos > w_top) ? w_top : w_rd_pos;
    assign w_short  = (w_idx == w_top);
    assign w_last   = ((CW'(r_ptr) + CW'(2)) == r_count);

    always_comb begin
        if (r_count == '0 || r_push_value >= w_rd_max) begin
            w_push_max = r_push_value;
            w_push_pos = AW'(r_count);
        end else begin
            w_push_max = w_rd_max;
            w_push_pos = w_rd_pos;
        end
        if (!r_run_ok || w_rd_val >= r_run_max) begin
            w_step_max = w_rd_val;
            w_step_pos = r_ptr;
        end else begin
            w_step_max = r_run_max;
            w_step_pos = r_run_pos;
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_ptr;
        w_wdata = {w_step_pos, w_step_max, w_rd_val};
        w_re    = 1'b0;
        w_raddr = w_top;
        case (i_ctl.op)
            mxs_pkg::DP_LOAD: begin
                w_re = 1'b1;
            end
            mxs_pkg::DP_PUSH: begin
                w_we    = 1'b1;
                w_waddr = AW'(r_count);
                w_wdata = {w_push_pos, w_push_max, r_push_value};
            end
            mxs_pkg::DP_PM_START: begin
                w_re    = !w_short;
                w_raddr = (w_idx == '0) ? (w_idx + AW'(1)) : (w_idx - AW'(1));
            end
            mxs_pkg::DP_PM_BASE: begin
                w_re    = 1'b1;
                w_raddr = r_ptr + AW'(1);
            end
            mxs_pkg::DP_PM_STEP: begin
                w_we    = 1'b1;
                w_re    = !w_last;
                w_raddr = r_ptr + AW'(2);
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (i_ctl.op)
                mxs_pkg::DP_PUSH: begin
                    r_count <= r_count + CW'(1);
                end
                mxs_pkg::DP_POP: begin
                    r_count <= r_count - CW'(1);
                end
                mxs_pkg::DP_PM_START: begin
                    if (w_short) begin
                        r_count <= r_count - CW'(1);
                    end
                end
                mxs_pkg::DP_PM_STEP: begin
                    if (w_last) begin
                        r_count <= r_count - CW'(1);
                    end
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
            if (i_ctl.op == mxs_pkg::DP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            mxs_pkg::DP_LOAD: begin
                r_push_value <= VALUE_WIDTH'(signed'(i_push_value));
                r_res_value  <= '0;
                r_res_status <= i_ctl.code;
            end
            mxs_pkg::DP_POP, mxs_pkg::DP_TOP: begin
                r_res_value <= 32'(w_rd_val);
            end
            mxs_pkg::DP_PEEK: begin
                r_res_value <= 32'(w_rd_max);
            end
            mxs_pkg::DP_PM_START: begin
                r_res_value <= 32'(w_rd_max);
                r_ptr       <= w_idx;
                r_run_ok    <= 1'b0;
            end
            mxs_pkg::DP_PM_BASE: begin
                r_run_max <= w_rd_max;
                r_run_pos <= w_rd_pos;
                r_run_ok  <= 1'b1;
            end
            mxs_pkg::DP_PM_STEP: begin
                r_run_max <= w_step_max;
                r_run_pos <= w_step_pos;
                r_run_ok  <= 1'b1;
                r_ptr     <= r_ptr + AW'(1);
            end
            mxs_pkg::DP_OUT: begin
                r_out_value  <= r_res_value;
                r_out_status <= r_res_status;
            end
            default: begin
                r_ptr <= r_ptr;
            end
        endcase
    end

    assign o_stat.empty       = (r_count == '0);
    assign o_stat.full        = (r_count == CW'(STACK_DEPTH));
    assign o_stat.out_free    = !r_out_valid || i_out_ready;
    assign o_stat.pm_short    = w_short;
    assign o_stat.pm_idx_zero = (w_idx == '0);
    assign o_stat.pm_last     = w_last;

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_out_value;
    assign o_status     = r_out_status;

endmodule

>>> rtl/max_stack_core.sv
// Top level of the max stack block: stack of signed values with running maximum.
//
// Each command transfer yields exactly one result transfer. Push, pop, top and
// peek-max go from accept to result by reading the top entry from the
// single-port-read entry memory, acting on it, and loading the output register.
// Pop-max also walks the entries above the removed maximum, after fetching the
// prefix below it when the maximum is not the bottom entry, since the shift and
// prefix recompute go through the memory one entry per cycle. Commands rejected
// as empty, full or unused skip the work step and go straight to the output
// register. One command is in flight at a time; the next one is taken as soon as
// the previous result sits in the output register and that register can be
// emptied. No clearing pass is needed after reset.
module max_stack_core #(
    parameter int STACK_DEPTH = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // [31:0] push_value
    input  logic [2:0]  i_s_axis_tuser,  // [2:0] cmd
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,  // [31:0] read_value
    output logic [1:0]  o_m_axis_tuser   // [1:0] status
);

    mxs_pkg::t_dp_ctl  w_ctl;
    mxs_pkg::t_dp_stat w_stat;

    mxs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_s_axis_tvalid),
        .i_cmd     (i_s_axis_tuser),
        .i_stat    (w_stat),
        .o_in_ready(o_s_axis_tready),
        .o_ctl     (w_ctl)
    );

    mxs_dp #(
        .STACK_DEPTH(STACK_DEPTH),
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_push_value(i_s_axis_tdata),
        .i_out_ready (i_m_axis_tready),
        .o_stat      (w_stat),
        .o_out_valid (o_m_axis_tvalid),
        .o_read_value(o_m_axis_tdata),
        .o_status    (o_m_axis_tuser)
    );

`ifndef SYNTHESIS
    a_ready_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("input ready while result register cannot drain");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("second command taken while one is in flight");

    a_error_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser != mxs_pkg::ST_OK) |-> (o_m_axis_tdata == '0))
        else $error("nonzero read value with error status");

    a_not_empty_and_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_stat.empty && w_stat.full))
        else $error("stack count reports empty and full together");
`endif

endmodule
